### sv/ofia_pkg.sv
package ofia_pkg;

  localparam int FIELD_BITS  = 32;
  localparam int NUM_BITS    = 64;
  localparam int DEN_BITS    = 48;
  localparam int OUT_BITS    = 17;
  localparam int QDIV_STEPS  = 15;
  localparam int QUEUE_DEPTH = 2;

  localparam int CMD_BITS = 2;
  localparam logic [CMD_BITS-1:0] CMD_TICK_BUY  = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_TICK_SELL = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_TICK_MID  = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_FLUSH     = 2'd3;

endpackage

### sv/ofia_if.sv
interface ofia_req_if;
  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic [ofia_pkg::FIELD_BITS-1:0]  trade_price;
  logic [ofia_pkg::FIELD_BITS-1:0]  bid_price;
  logic [ofia_pkg::FIELD_BITS-1:0]  ask_price;
  logic [ofia_pkg::FIELD_BITS-1:0]  trade_size;

  modport source (output valid, req_type, trade_price, bid_price, ask_price, trade_size,
                  input ready);
  modport sink (input valid, req_type, trade_price, bid_price, ask_price, trade_size,
                output ready);
endinterface

interface ofia_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [ofia_pkg::OUT_BITS-1:0] imbalance;

  modport source (output valid, imbalance, input ready);
  modport sink (input valid, imbalance, output ready);
endinterface

### sv/ofia_front.sv
module ofia_front #(
  parameter int PW = 32,
  parameter int SW = 32,
  parameter int EW = ofia_pkg::CMD_BITS + 1 + 2 * PW + SW
) (
  ofia_req_if.sink        req,
  input  logic            full,
  output logic            push,
  output logic [EW-1:0]   push_data
);

  typedef struct packed {
    logic [ofia_pkg::CMD_BITS-1:0] cmd;
    logic                          neg;
    logic [PW-1:0]                 rem;
    logic [PW-1:0]                 spread;
    logic [SW-1:0]                 size;
  } entry_t;

  entry_t      entry;
  logic [PW-1:0] p;
  logic [PW-1:0] b;
  logic [PW-1:0] a;
  logic [PW:0]   twice;
  logic [PW:0]   sumq;
  logic [PW:0]   diff;
  logic          neg;

  assign p = req.trade_price[PW-1:0];
  assign b = req.bid_price[PW-1:0];
  assign a = req.ask_price[PW-1:0];

  assign twice = {p, 1'b0};
  assign sumq  = {1'b0, a} + {1'b0, b};
  assign neg   = twice < sumq;
  assign diff  = neg ? (sumq - twice) : (twice - sumq);

  always_comb begin
    entry.neg    = neg;
    entry.rem    = diff[PW-1:0];
    entry.spread = a - b;
    entry.size   = req.trade_size[SW-1:0];
    if (req.req_type) begin
      entry.cmd = ofia_pkg::CMD_FLUSH;
    end else if (p >= a) begin
      entry.cmd = ofia_pkg::CMD_TICK_BUY;
    end else if (p <= b) begin
      entry.cmd = ofia_pkg::CMD_TICK_SELL;
    end else begin
      entry.cmd = ofia_pkg::CMD_TICK_MID;
    end
  end

  // degenerate quotes are consumed without a queue entry
  assign req.ready = !full;
  assign push      = req.valid && !full && (req.req_type || (a > b));
  assign push_data = entry;

endmodule

### sv/ofia_fifo.sv
module ofia_fifo #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output logic          empty
);

  localparam int DEPTH = ofia_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full     = count == CW'(DEPTH);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/ofia_back.sv
module ofia_back #(
  parameter int PW   = 32,
  parameter int SW   = 32,
  parameter int FRAC = 16,
  parameter int EW   = ofia_pkg::CMD_BITS + 1 + 2 * PW + SW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [EW-1:0] pop_data,
  input  logic          empty,
  output logic          pop,
  ofia_rsp_if.source    rsp
);

  localparam int NB = ofia_pkg::NUM_BITS;
  localparam int DB = ofia_pkg::DEN_BITS;
  localparam int OB = ofia_pkg::OUT_BITS;
  localparam int QS = ofia_pkg::QDIV_STEPS;
  localparam int RW = DB + 1;
  localparam int QW = (FRAC > QS) ? FRAC : QS;
  localparam int CW = $clog2(QW + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TDIV   = 3'd1;
  localparam logic [2:0] S_TMUL   = 3'd2;
  localparam logic [2:0] S_TACC   = 3'd3;
  localparam logic [2:0] S_FSTART = 3'd4;
  localparam logic [2:0] S_FDIV   = 3'd5;
  localparam logic [2:0] S_FEMIT  = 3'd6;

  typedef struct packed {
    logic [ofia_pkg::CMD_BITS-1:0] cmd;
    logic                          neg;
    logic [PW-1:0]                 rem;
    logic [PW-1:0]                 spread;
    logic [SW-1:0]                 size;
  } entry_t;

  entry_t           entry;
  logic [2:0]       state;
  logic [NB-1:0]    num;
  logic [DB-1:0]    den;
  logic [RW-1:0]    rem;
  logic [DB-1:0]    divisor;
  logic [QW-1:0]    quo;
  logic [CW-1:0]    cnt;
  logic [SW-1:0]    vsize;
  logic [SW-1:0]    vmag;
  logic             vneg;
  logic             fneg;
  logic [QS:0]      qmag;
  logic             ovalid;
  logic [OB-1:0]    odata;

  logic [RW-1:0]    shifted;
  logic             ge;
  logic [RW-1:0]    rem_step;
  logic [QW-1:0]    quo_step;
  logic [SW+FRAC-1:0] prod;
  logic [NB:0]      sv_ext;
  logic [NB:0]      sv;
  logic [NB:0]      nsum;
  logic [DB:0]      dsum;
  logic [NB-1:0]    mag64;

  assign entry = pop_data;
  assign pop   = (state == S_IDLE) && !empty;

  // one restoring division step
  assign shifted  = {rem[RW-2:0], 1'b0};
  assign ge       = shifted >= {1'b0, divisor};
  assign rem_step = ge ? (shifted - {1'b0, divisor}) : shifted;
  assign quo_step = {quo[QW-2:0], ge};

  assign prod   = vsize * quo[FRAC-1:0];
  assign sv_ext = {{(NB + 1 - SW){1'b0}}, vmag};
  assign sv     = vneg ? (~sv_ext + 1'b1) : sv_ext;
  assign nsum   = {num[NB-1], num} + sv;
  assign dsum   = {1'b0, den} + {{(DB + 1 - SW){1'b0}}, vsize};
  assign mag64  = num[NB-1] ? (NB'(0) - num) : num;

  assign rsp.valid     = ovalid;
  assign rsp.imbalance = odata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      num    <= '0;
      den    <= '0;
      ovalid <= 1'b0;
    end else begin
      if (rsp.ready && (state != S_FEMIT)) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!empty) begin
            vsize   <= entry.size;
            rem     <= {{(RW - PW){1'b0}}, entry.rem};
            divisor <= {{(DB - PW){1'b0}}, entry.spread};
            quo     <= '0;
            case (entry.cmd)
              ofia_pkg::CMD_TICK_BUY: begin
                vmag  <= entry.size;
                vneg  <= 1'b0;
                state <= S_TACC;
              end
              ofia_pkg::CMD_TICK_SELL: begin
                vmag  <= entry.size;
                vneg  <= 1'b1;
                state <= S_TACC;
              end
              ofia_pkg::CMD_TICK_MID: begin
                vneg  <= entry.neg;
                cnt   <= CW'(FRAC);
                state <= S_TDIV;
              end
              default: begin
                state <= S_FSTART;
              end
            endcase
          end
        end
        S_TDIV: begin
          rem <= rem_step;
          quo <= quo_step;
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            state <= S_TMUL;
          end
        end
        S_TMUL: begin
          vmag  <= prod[SW+FRAC-1:FRAC];
          state <= S_TACC;
        end
        S_TACC: begin
          if (nsum[NB] != nsum[NB-1]) begin
            num <= nsum[NB] ? {1'b1, {(NB - 1){1'b0}}} : {1'b0, {(NB - 1){1'b1}}};
          end else begin
            num <= nsum[NB-1:0];
          end
          den   <= dsum[DB] ? {DB{1'b1}} : dsum[DB-1:0];
          state <= S_IDLE;
        end
        S_FSTART: begin
          fneg    <= num[NB-1];
          rem     <= {1'b0, mag64[DB-1:0]};
          divisor <= den;
          quo     <= '0;
          cnt     <= CW'(QS);
          if (den == '0) begin
            qmag  <= '0;
            state <= S_FEMIT;
          end else if (mag64 >= {{(NB - DB){1'b0}}, den}) begin
            qmag  <= {1'b1, {QS{1'b0}}};
            state <= S_FEMIT;
          end else begin
            state <= S_FDIV;
          end
        end
        S_FDIV: begin
          rem <= rem_step;
          quo <= quo_step;
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            qmag  <= {1'b0, quo_step[QS-1:0]};
            state <= S_FEMIT;
          end
        end
        S_FEMIT: begin
          if (!ovalid || rsp.ready) begin
            ovalid <= 1'b1;
            odata  <= fneg ? (OB'(0) - {1'b0, qmag}) : {1'b0, qmag};
            num    <= '0;
            den    <= '0;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/order_flow_imbalance_accumulator.sv
// a tick inside the spread is divided, scaled and accumulated; a tick at or beyond a quote is
// only accumulated; a flush runs the shared restoring divider (skipped for a zero or saturating
// result) and waits for the output register to be free; one transaction per back-end pass, with
// the next queue entry popped only when the pass is done; queue of two
// degenerate-quote ticks are consumed by the front end and never reach the queue
// reset: synchronous, clears both sums, the queue and the output valid
module order_flow_imbalance_accumulator #(
  parameter int PRICE_BITS = 32,
  parameter int SIZE_BITS  = 32,
  parameter int FRAC_BITS  = 16
) (
  input logic        clk,
  input logic        rst,
  ofia_req_if.sink   req,
  ofia_rsp_if.source rsp
);

  localparam int PW = (PRICE_BITS < ofia_pkg::FIELD_BITS) ? PRICE_BITS : ofia_pkg::FIELD_BITS;
  localparam int SW = (SIZE_BITS < ofia_pkg::FIELD_BITS) ? SIZE_BITS : ofia_pkg::FIELD_BITS;
  localparam int EW = ofia_pkg::CMD_BITS + 1 + 2 * PW + SW;

  logic          push;
  logic [EW-1:0] push_data;
  logic          full;
  logic          pop;
  logic [EW-1:0] pop_data;
  logic          empty;

  ofia_front #(.PW(PW), .SW(SW), .EW(EW)) u_front (
    .req       (req),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  ofia_fifo #(.DW(EW)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  ofia_back #(.PW(PW), .SW(SW), .FRAC(FRAC_BITS), .EW(EW)) u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_data (pop_data),
    .empty    (empty),
    .pop      (pop),
    .rsp      (rsp)
  );

endmodule

### tb/tb_order_flow_imbalance_accumulator.sv
module tb_order_flow_imbalance_accumulator;

  localparam int FRAC = 16;
  localparam logic [31:0] WORD_MAX = 32'hFFFF_FFFF;
  localparam logic [47:0] DEN_CEIL = 48'hFFFF_FFFF_FFFF;
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;
  localparam int RANDOM_ITEMS = 820;
  localparam int BIG_TICKS = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 60;

  class imbalance_book;
    logic [63:0] num;
    logic [47:0] den;
    logic signed [ofia_pkg::OUT_BITS-1:0] imbalance_due[$];
    int faults;

    function new();
      num = '0;
      den = '0;
      faults = 0;
    endfunction

    function void take_request(logic rtype, logic [31:0] p, logic [31:0] b,
                               logic [31:0] a, logic [31:0] s);
      logic [63:0] spread, twice, sumq, rem, frac, mag, vol, q;
      logic [64:0] nsum;
      logic [48:0] dsum;
      logic [ofia_pkg::OUT_BITS-1:0] res;
      bit neg;
      if (rtype == REQ_FLUSH) begin
        res = '0;
        if (den != 0) begin
          neg = num[63];
          mag = neg ? -num : num;
          q = (mag >= {16'd0, den}) ? 64'd32768 : (mag << 15) / {16'd0, den};
          res = neg ? -q[ofia_pkg::OUT_BITS-1:0] : q[ofia_pkg::OUT_BITS-1:0];
        end
        imbalance_due.push_back(res);
        num = '0;
        den = '0;
        return;
      end
      if (a <= b) return;
      if (p >= a) begin
        vol = {32'd0, s};
      end else if (p <= b) begin
        vol = -{32'd0, s};
      end else begin
        spread = {32'd0, a} - {32'd0, b};
        twice = {31'd0, p, 1'b0};
        sumq = {32'd0, a} + {32'd0, b};
        neg = twice < sumq;
        rem = neg ? sumq - twice : twice - sumq;
        frac = '0;
        for (int i = 0; i < FRAC; i++) begin
          rem = rem << 1;
          frac = frac << 1;
          if (rem >= spread) begin
            rem = rem - spread;
            frac[0] = 1'b1;
          end
        end
        mag = ({32'd0, s} * frac) >> FRAC;
        vol = neg ? -mag : mag;
      end
      nsum = {num[63], num} + {vol[63], vol};
      if (nsum[64] != nsum[63])
        num = nsum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      else
        num = nsum[63:0];
      dsum = {1'b0, den} + {17'd0, s};
      den = dsum[48] ? DEN_CEIL : dsum[47:0];
    endfunction

    function void check_imbalance(logic signed [ofia_pkg::OUT_BITS-1:0] got);
      logic signed [ofia_pkg::OUT_BITS-1:0] want;
      if (imbalance_due.size() == 0) begin
        if (faults < 10) $display("unexpected imbalance %0d", got);
        faults++;
        return;
      end
      want = imbalance_due.pop_front();
      if (got !== want) begin
        if (faults < 10) $display("imbalance mismatch: expected %0d, got %0d", want, got);
        faults++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit tx_quiet;
  bit rx_quiet;
  bit hold_request;
  imbalance_book book;

  ofia_req_if req_ch();
  ofia_rsp_if rsp_ch();

  order_flow_imbalance_accumulator #(
    .PRICE_BITS(32),
    .SIZE_BITS(32),
    .FRAC_BITS(FRAC)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic send_req(input logic rtype, input logic [31:0] p, input logic [31:0] b,
                          input logic [31:0] a, input logic [31:0] s);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= rtype;
    req_ch.trade_price <= p;
    req_ch.bid_price <= b;
    req_ch.ask_price <= a;
    req_ch.trade_size <= s;
    do @(posedge clk); while (!req_ch.ready);
    book.take_request(rtype, p, b, a, s);
  endtask

  task automatic send_flush();
    send_req(REQ_FLUSH, $urandom, $urandom, $urandom, $urandom);
  endtask

  // result side
  initial begin : receiver
    int stall;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, 8);
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      book.check_imbalance(rsp_ch.imbalance);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle = 0;
      else
        idle++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int counted, bar, nticks, sk, qk, pk;
    logic [31:0] p, b, a, s, x, y, spread;
    book = new();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    hold_request = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_TICK;
    req_ch.trade_price = '0;
    req_ch.bid_price = '0;
    req_ch.ask_price = '0;
    req_ch.trade_size = '0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty flush, full buy, full sell
    send_flush();
    send_req(REQ_TICK, WORD_MAX, 32'd0, WORD_MAX, WORD_MAX);
    send_flush();
    send_req(REQ_TICK, 32'd0, 32'd0, 32'd1, WORD_MAX);
    send_flush();
    // inside the widest spread
    send_req(REQ_TICK, 32'h8000_0000, 32'd0, WORD_MAX, WORD_MAX);
    send_req(REQ_TICK, 32'h7FFF_FFFF, 32'd0, WORD_MAX, WORD_MAX);
    send_req(REQ_TICK, 32'd1, 32'd0, WORD_MAX, WORD_MAX);
    send_req(REQ_TICK, WORD_MAX - 1, 32'd0, WORD_MAX, WORD_MAX);
    send_flush();
    // degenerate quotes only
    send_req(REQ_TICK, 32'd5, 32'd7, 32'd7, WORD_MAX);
    send_req(REQ_TICK, WORD_MAX, WORD_MAX, 32'd0, WORD_MAX);
    send_flush();
    // zero size
    send_req(REQ_TICK, 32'd10, 32'd0, 32'd5, 32'd0);
    send_req(REQ_TICK, 32'd3, 32'd0, 32'd5, 32'd0);
    send_flush();
    // exact midpoint, nonzero denominator
    send_req(REQ_TICK, 32'd101, 32'd100, 32'd102, WORD_MAX);
    send_flush();
    send_req(REQ_TICK, 32'd200, 32'd100, 32'd102, 32'd3);
    send_req(REQ_TICK, 32'd0, 32'd100, 32'd102, 32'd1);
    send_flush();
    send_req(REQ_TICK, WORD_MAX, 32'd3, 32'd5, 32'd12345);
    send_req(REQ_TICK, 32'd4, 32'd3, 32'd9, 32'd777);
    send_flush();

    // large sums back to back
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    repeat (BIG_TICKS) send_req(REQ_TICK, WORD_MAX, 32'd0, WORD_MAX, WORD_MAX);
    send_req(REQ_TICK, 32'd0, 32'd10, 32'd20, 32'd1000);
    send_req(REQ_TICK, 32'd15, 32'd10, 32'd20, WORD_MAX);
    send_flush();

    counted = 0;
    bar = 0;
    while (counted < RANDOM_ITEMS) begin
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      if (bar == 30) begin
        // stall the result side while requests keep coming
        tx_quiet = 1'b1;
        hold_request = 1'b1;
        repeat (10) begin
          send_flush();
          send_req(REQ_TICK, 32'd50, 32'd40, 32'd60, $urandom_range(1, 100));
        end
        counted += 20;
      end
      nticks = (bar == 30) ? 0 : $urandom_range(0, 10);
      for (int k = 0; k < nticks; k++) begin
        sk = $urandom_range(0, 9);
        if (sk == 0) s = 32'd0;
        else if (sk == 1) s = WORD_MAX;
        else if (sk < 5) s = $urandom;
        else s = $urandom_range(1, 5000);
        qk = $urandom_range(0, 9);
        if (qk == 0) begin
          b = $urandom;
          a = $urandom_range(0, b);
        end else if (qk < 3) begin
          x = $urandom;
          y = $urandom;
          b = (x < y) ? x : y;
          a = (x < y) ? y : x;
        end else begin
          spread = (qk < 6) ? $urandom_range(1, 64) : $urandom_range(1, 32'h0010_0000);
          b = $urandom_range(0, WORD_MAX - spread);
          a = b + spread;
        end
        pk = $urandom_range(0, 9);
        if (pk == 0) p = a;
        else if (pk == 1) p = b;
        else if (pk == 2) p = $urandom_range(a, WORD_MAX);
        else if (pk == 3) p = $urandom_range(0, b);
        else if (a > b + 1) p = $urandom_range(b + 1, a - 1);
        else p = $urandom;
        send_req(REQ_TICK, p, b, a, s);
        counted++;
      end
      send_flush();
      counted++;
      bar++;
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (book.imbalance_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (book.faults == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
